/* rtl/wheel_fault_hysteresis_monitor_unit_defines.svh */
// assertion macros for the wheel fault hysteresis monitor
`ifndef WHEEL_FAULT_HYSTERESIS_MONITOR_UNIT_DEFINES_SVH
`define WHEEL_FAULT_HYSTERESIS_MONITOR_UNIT_DEFINES_SVH

// same-cycle implication, clocked on clk, quiet during reset
`define WHFM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, quiet during reset
`define WHFM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/whfm_pkg.sv */
// types, codes and constants of the wheel fault hysteresis monitor
`timescale 1ns / 1ps
package whfm_pkg;
	localparam int MAX_WHEELS = 8;
	localparam int WHEEL_W = 3;
	localparam int WIU_W = 4;
	localparam int MAG_W = 15;
	localparam int CNT_W = 16;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W = 3;

	localparam logic [MAG_W-1:0] MAG_MAX = '1;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	typedef enum logic [1:0] {
		KIND_SAMPLE = 2'd0,
		KIND_RESET  = 2'd1,
		KIND_CLEAR  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_DEGRADED = 2'd1,
		ST_INVALID  = 2'd2
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WHEELS_IN_USE      = 3'd0,
		REG_FAULT_THRESHOLD    = 3'd1,
		REG_RECOVERY_THRESHOLD = 3'd2,
		REG_FAULT_SAMPLES      = 3'd3,
		REG_RECOVERY_SAMPLES   = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic             ok;
		logic [WIU_W-1:0] wheels_in_use;
		logic [MAG_W-1:0] fault_threshold;
		logic [MAG_W-1:0] recovery_threshold;
		logic [CNT_W-1:0] fault_samples;
		logic [CNT_W-1:0] recovery_samples;
	} cfg_t;

	typedef struct packed {
		logic [MAG_W-1:0] mag;
		logic [CNT_W-1:0] high_cnt;
		logic [CNT_W-1:0] low_cnt;
	} entry_t;
endpackage

/* rtl/whfm_if.sv */
// handshake channels for items and results
`timescale 1ns / 1ps
interface whfm_item_if;
	import whfm_pkg::*;
	logic               valid;
	logic               ready;
	logic [1:0]         kind;
	logic [WHEEL_W-1:0] wheel;
	logic signed [15:0] residual;
	logic               sensor_present;
	logic               start_healthy;

	modport source (output valid, kind, wheel, residual, sensor_present, start_healthy,
		input ready);
	modport sink (input valid, kind, wheel, residual, sensor_present, start_healthy,
		output ready);
endinterface

interface whfm_result_if;
	import whfm_pkg::*;
	logic             valid;
	logic             ready;
	logic [1:0]       status;
	logic             wheel_available;
	logic [MAG_W-1:0] residual_magnitude;
	logic [CNT_W-1:0] fault_count;
	logic [CNT_W-1:0] recovery_count;

	modport source (output valid, status, wheel_available, residual_magnitude, fault_count,
		recovery_count, input ready);
	modport sink (input valid, status, wheel_available, residual_magnitude, fault_count,
		recovery_count, output ready);
endinterface

/* rtl/whfm_cfg_regs.sv */
// configuration registers and configuration check
`timescale 1ns / 1ps
module whfm_cfg_regs import whfm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);
	logic [WIU_W-1:0] wiu_q;
	logic [MAG_W-1:0] fthr_q;
	logic [MAG_W-1:0] rthr_q;
	logic [CNT_W-1:0] fsmp_q;
	logic [CNT_W-1:0] rsmp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wiu_q  <= WIU_W'(4);
			fthr_q <= MAG_W'(256);
			rthr_q <= MAG_W'(128);
			fsmp_q <= CNT_W'(3);
			rsmp_q <= CNT_W'(3);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WHEELS_IN_USE:      wiu_q  <= cfg_data[WIU_W-1:0];
				REG_FAULT_THRESHOLD:    fthr_q <= cfg_data[MAG_W-1:0];
				REG_RECOVERY_THRESHOLD: rthr_q <= cfg_data[MAG_W-1:0];
				REG_FAULT_SAMPLES:      fsmp_q <= cfg_data[CNT_W-1:0];
				REG_RECOVERY_SAMPLES:   rsmp_q <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.wheels_in_use      = wiu_q;
		cfg.fault_threshold    = fthr_q;
		cfg.recovery_threshold = rthr_q;
		cfg.fault_samples      = fsmp_q;
		cfg.recovery_samples   = rsmp_q;
		cfg.ok = (wiu_q != '0) && (wiu_q <= WIU_W'(MAX_WHEELS)) && (fthr_q != '0) &&
			(rthr_q < fthr_q) && (fsmp_q != '0) && (rsmp_q != '0);
	end
endmodule

/* rtl/whfm_entry_ram.sv */
// per-wheel count and magnitude memory, one read and one write port
`timescale 1ns / 1ps
module whfm_entry_ram import whfm_pkg::*; (
	input  logic               clk,
	input  logic               rd_en,
	input  logic [WHEEL_W-1:0] rd_addr,
	output entry_t             rd_data,
	input  logic               wr_en,
	input  logic [WHEEL_W-1:0] wr_addr,
	input  entry_t             wr_data
);
	entry_t mem [MAX_WHEELS];
	entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
	end

	// old data on a same-address collision, caller forwards
	always_ff @(posedge clk) begin
		if (rd_en)
			rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;
endmodule

/* rtl/whfm_update.sv */
// next wheel state for a sample or a single-wheel reset
`timescale 1ns / 1ps
module whfm_update import whfm_pkg::*; (
	input  cfg_t               cfg,
	input  logic [1:0]         kind,
	input  logic signed [15:0] residual,
	input  logic               sensor_present,
	input  logic               start_healthy,
	input  entry_t             ent_in,
	input  logic               faulted_in,
	output entry_t             ent_out,
	output logic               faulted_out
);
	logic [15:0]      neg;
	logic [MAG_W-1:0] mag;
	logic [CNT_W-1:0] hi_inc;
	logic [CNT_W-1:0] lo_inc;

	always_comb begin
		neg = 16'(-residual);
		if (residual[15])
			mag = (neg[15]) ? MAG_MAX : neg[MAG_W-1:0];
		else
			mag = residual[MAG_W-1:0];
		hi_inc = (ent_in.high_cnt == CNT_MAX) ? CNT_MAX : ent_in.high_cnt + 1'b1;
		lo_inc = (ent_in.low_cnt == CNT_MAX) ? CNT_MAX : ent_in.low_cnt + 1'b1;

		ent_out     = ent_in;
		faulted_out = faulted_in;
		case (kind)
			KIND_SAMPLE: begin
				ent_out.mag = mag;
				if (!sensor_present) begin
					faulted_out      = 1'b1;
					ent_out.high_cnt = cfg.fault_samples;
					ent_out.low_cnt  = '0;
				end else if (!faulted_in) begin
					ent_out.low_cnt = '0;
					if (mag >= cfg.fault_threshold) begin
						ent_out.high_cnt = hi_inc;
						if (hi_inc >= cfg.fault_samples)
							faulted_out = 1'b1;
					end else begin
						ent_out.high_cnt = '0;
					end
				end else begin
					ent_out.high_cnt = '0;
					if (mag <= cfg.recovery_threshold) begin
						if (lo_inc >= cfg.recovery_samples) begin
							faulted_out     = 1'b0;
							ent_out.low_cnt = '0;
						end else begin
							ent_out.low_cnt = lo_inc;
						end
					end else begin
						ent_out.low_cnt = '0;
					end
				end
			end
			KIND_RESET: begin
				ent_out     = '0;
				faulted_out = !start_healthy;
			end
			default: ;
		endcase
	end
endmodule

/* rtl/wheel_fault_hysteresis_monitor_unit.sv */
// top level of the wheel fault hysteresis monitor
`timescale 1ns / 1ps
// path: an accepted item is registered into stage 1 along with its memory read, then
//   is updated into the result register once that register is free or drained
// throughput: one item per cycle unless a held result stalls stage 1; the entry memory is
//   written back as the item leaves stage 1; a forwarding register serves same-wheel collisions
// reset: asynchronous, active low; all wheels healthy with zero counts at once
//   (per-entry valid bits, no clearing pass), registers back to their defaults
module wheel_fault_hysteresis_monitor_unit import whfm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	whfm_item_if.sink             req,
	whfm_result_if.source         rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);
`include "wheel_fault_hysteresis_monitor_unit_defines.svh"

	cfg_t cfg;

	// stage 1: item waiting on its memory read
	logic               vld_s1;
	logic [1:0]         kind_s1;
	logic [WHEEL_W-1:0] wheel_s1;
	logic signed [15:0] residual_s1;
	logic               present_s1;
	logic               assume_s1;

	// per-wheel flags kept in flops so degraded can see all wheels at once
	logic [MAX_WHEELS-1:0] faulted_q;
	logic [MAX_WHEELS-1:0] ent_vld_q;

	// last write into the entry memory, for read-after-write collisions
	logic               fwd_vld_q;
	logic [WHEEL_W-1:0] fwd_addr_q;
	entry_t             fwd_data_q;

	// output register
	logic             out_vld_q;
	status_t          status_q;
	logic             avail_q;
	logic [MAG_W-1:0] mag_q;
	logic [CNT_W-1:0] hi_q;
	logic [CNT_W-1:0] lo_q;

	logic   in_acc;
	logic   adv;
	entry_t rd_data;
	entry_t ent_cur;
	entry_t ent_new;
	logic   faulted_new;
	logic   item_ok;
	logic   wr_en;
	logic   is_clear;
	logic [MAX_WHEELS-1:0] faulted_next;
	logic [MAX_WHEELS-1:0] in_use_mask;

	whfm_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// stage 1 moves on whenever the output register is free or drained
	assign adv       = vld_s1 && (!out_vld_q || rsp.ready);
	assign req.ready = !vld_s1 || adv;
	assign in_acc    = req.valid && req.ready;

	whfm_entry_ram u_ram (
		.clk     (clk),
		.rd_en   (in_acc),
		.rd_addr (req.wheel),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wheel_s1),
		.wr_data (ent_new)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (req.ready)
			vld_s1 <= req.valid;
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			kind_s1     <= req.kind;
			wheel_s1    <= req.wheel;
			residual_s1 <= req.residual;
			present_s1  <= req.sensor_present;
			assume_s1   <= req.start_healthy;
		end
	end

	// current entry: cleared wheels read as zero, fresh writes come from the bypass
	always_comb begin
		if (!ent_vld_q[wheel_s1])
			ent_cur = '0;
		else if (fwd_vld_q && (fwd_addr_q == wheel_s1))
			ent_cur = fwd_data_q;
		else
			ent_cur = rd_data;
	end

	whfm_update u_upd (
		.cfg            (cfg),
		.kind           (kind_s1),
		.residual       (residual_s1),
		.sensor_present (present_s1),
		.start_healthy  (assume_s1),
		.ent_in         (ent_cur),
		.faulted_in     (faulted_q[wheel_s1]),
		.ent_out        (ent_new),
		.faulted_out    (faulted_new)
	);

	// kind 3, out-of-range wheels and any item under a bad configuration are rejected, clear skips the index check
	always_comb begin
		is_clear = (kind_s1 == KIND_CLEAR);
		item_ok  = cfg.ok && (kind_s1 == KIND_SAMPLE || kind_s1 == KIND_RESET || is_clear) &&
			(is_clear || ({1'b0, wheel_s1} < cfg.wheels_in_use));
		wr_en    = adv && item_ok && !is_clear;

		faulted_next = faulted_q;
		if (is_clear)
			faulted_next = '0;
		else
			faulted_next[wheel_s1] = faulted_new;

		for (int i = 0; i < MAX_WHEELS; i++)
			in_use_mask[i] = (WIU_W'(i) < cfg.wheels_in_use);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			faulted_q <= '0;
			ent_vld_q <= '0;
			fwd_vld_q <= 1'b0;
		end else if (adv && item_ok) begin
			faulted_q <= faulted_next;
			if (is_clear) begin
				ent_vld_q <= '0;
				fwd_vld_q <= 1'b0;
			end else begin
				ent_vld_q[wheel_s1] <= 1'b1;
				fwd_vld_q           <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			fwd_addr_q <= wheel_s1;
			fwd_data_q <= ent_new;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (adv)
			out_vld_q <= 1'b1;
		else if (rsp.ready)
			out_vld_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (!item_ok) begin
				status_q <= ST_INVALID;
				avail_q  <= 1'b0;
				mag_q    <= '0;
				hi_q     <= '0;
				lo_q     <= '0;
			end else begin
				status_q <= (|(faulted_next & in_use_mask)) ? ST_DEGRADED : ST_OK;
				if (is_clear) begin
					avail_q <= 1'b1;
					mag_q   <= '0;
					hi_q    <= '0;
					lo_q    <= '0;
				end else begin
					avail_q <= !faulted_new;
					mag_q   <= ent_new.mag;
					hi_q    <= ent_new.high_cnt;
					lo_q    <= ent_new.low_cnt;
				end
			end
		end
	end

	assign rsp.valid              = out_vld_q;
	assign rsp.status             = status_q;
	assign rsp.wheel_available    = avail_q;
	assign rsp.residual_magnitude = mag_q;
	assign rsp.fault_count        = hi_q;
	assign rsp.recovery_count     = lo_q;

	// an invalid answer carries nothing but its status
	`WHFM_ASSERT_NOW(a_invalid_zero, out_vld_q && status_q == ST_INVALID, !avail_q && mag_q == '0 && hi_q == '0 && lo_q == '0, "invalid result with nonzero fields")
	// a finished item always lands in the result register
	`WHFM_ASSERT_NEXT(a_adv_out, adv, out_vld_q, "stage 1 advanced without a result")
	// a clear leaves every wheel healthy and every entry unwritten
	`WHFM_ASSERT_NEXT(a_clear_all, adv && item_ok && is_clear, faulted_q == '0 && ent_vld_q == '0 && !fwd_vld_q, "clear did not wipe the wheel state")
	// a write-back marks its entry valid and arms the bypass
	`WHFM_ASSERT_NEXT(a_wr_mark, wr_en, ent_vld_q[$past(wheel_s1)] && fwd_vld_q && fwd_addr_q == $past(wheel_s1), "write-back not recorded")
endmodule
